FILE: src/fspa_pkg.sv
// Shared types and codes for the fixed-size pool allocator.
// Used by the controller, the datapath, the top level and the checker.
package fspa_pkg;

	// Fixed widths of the payload and the configuration port.
	localparam int ACTION_W    = 2;
	localparam int STATUS_W    = 2;
	localparam int ELEM_ADDR_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int EPB_W       = 7;
	localparam int STRIDE_W    = 16;
	localparam int BASE_W      = 32;

	// Reset values of the configuration registers.
	localparam logic [EPB_W-1:0]    EPB_RESET    = 7'd64;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd16;
	localparam logic [BASE_W-1:0]   BASE_RESET   = 32'd4096;

	// Actions carried by an input item.
	localparam logic [ACTION_W-1:0] ACT_ALLOC    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FREE_ALL = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOM       = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NULL_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENTS_PER_BLOCK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_STRIDE     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_POOL_BASE          = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                pop;            // read the top entry, advance the position
		logic                push;           // retreat the position, write the freed address
		logic                clear_pos;      // position back to zero
		logic                start_append;   // set up a fill of the next block
		logic                start_free_all; // set up a fill of every set-up entry
		logic                mul;            // first index times stride
		logic                add_base;       // pool base plus that product
		logic                fill;           // write one fresh address
		logic                bump_blocks;    // one more block is set up
		logic                load_out;       // load the output register
		logic [STATUS_W-1:0] out_status;
		logic                out_use_rd;     // result carries the popped address
	} fspa_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pos_ge_cap;  // every set-up entry is handed out
		logic blocks_full; // no further block may be appended
		logic pos_zero;    // nothing is handed out
		logic cap_zero;    // no entry is set up
		logic fill_last;   // the current fill write is the final one
		logic addr_null;   // the free address is null
	} fspa_sts_t;

endpackage

FILE: src/fixed_size_pool_allocator_core.sv
// Alloc from a set-up block, free and unknown actions take the request, then load the result.
// An appending alloc steps through mul, base, fill (one entry a cycle), check and result.
// Free-all refills every set-up entry, again one stack write a cycle, then loads the result.
// The next request waits until the result is loaded, which waits while the output is stalled.
// Reset (arst_n low, asynchronous): counters clear, config returns to defaults, the
// stack memory keeps its contents and needs no clearing pass.
module fixed_size_pool_allocator_core #(
	parameter int MAX_BLOCKS   = 16,
	parameter int BLOCK_DEPTH  = 64,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write port; writes are expected only while the block is idle.
	input  logic                                 cfg_write_enable,
	input  logic [fspa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fspa_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Request channel.
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [fspa_pkg::ACTION_W-1:0]        action,
	input  logic [fspa_pkg::ELEM_ADDR_W-1:0]     free_address,
	// Result channel.
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [fspa_pkg::ELEM_ADDR_W-1:0]     element_address,
	output logic [fspa_pkg::STATUS_W-1:0]        status
);
	import fspa_pkg::*;

	// The controller takes a request transfer only in its idle state and then
	// sequences the datapath. Allocation pops the stack entry at the current
	// position; when every set-up block is handed out, the next block is first
	// filled with fresh addresses (base plus index times stride), one memory
	// write per cycle, and the pop is retried against the larger capacity.
	// A free pushes the address back, unless it is null or nothing is handed
	// out. Free-all rewinds the position and refills every set-up entry.
	//
	// Each result lands in an output register. The controller returns to idle
	// as soon as the result is loaded, so the next request transfer can be
	// taken while the previous result still waits for its output transfer.

	fspa_cmd_t cmd;
	fspa_sts_t sts;

	fspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fspa_dp #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.BLOCK_DEPTH  (BLOCK_DEPTH),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.free_address     (free_address),
		.cmd              (cmd),
		.sts              (sts),
		.element_address  (element_address),
		.status           (status)
	);

endmodule

FILE: src/fspa_dp.sv
// Datapath of the pool allocator: configuration, counters, fill address
// generator, the free stack memory and the output register. Uses fspa_pkg.
module fspa_dp #(
	parameter int MAX_BLOCKS   = 16,
	parameter int BLOCK_DEPTH  = 64,
	parameter int ADDRESS_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write_enable,
	input  logic [fspa_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fspa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [fspa_pkg::ELEM_ADDR_W-1:0]     free_address,
	input  fspa_pkg::fspa_cmd_t                  cmd,
	output fspa_pkg::fspa_sts_t                  sts,
	output logic [fspa_pkg::ELEM_ADDR_W-1:0]     element_address,
	output logic [fspa_pkg::STATUS_W-1:0]        status
);
	import fspa_pkg::*;

	localparam int ENTRIES = MAX_BLOCKS * BLOCK_DEPTH;
	localparam int POS_W   = $clog2(ENTRIES + 1);
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
	localparam int LEN_W   = $clog2(BLOCK_DEPTH + 1);
	localparam int CMP_W   = (LEN_W > EPB_W) ? LEN_W : EPB_W;
	localparam int PROD_W  = POS_W + STRIDE_W;
	localparam int AW      = ADDRESS_BITS;

	logic [EPB_W-1:0]       epb_q;
	logic [STRIDE_W-1:0]    stride_q;
	logic [BASE_W-1:0]      base_q;
	logic [BLK_W-1:0]       blocks_q;
	logic [POS_W-1:0]       pos_q;
	logic [POS_W-1:0]       fill_idx_q;
	logic [POS_W-1:0]       fill_end_q;
	logic [PROD_W-1:0]      prod_q;
	logic [AW-1:0]          acc_q;
	logic [ELEM_ADDR_W-1:0] rd_q;
	logic [ELEM_ADDR_W-1:0] element_address_q;
	logic [STATUS_W-1:0]    status_q;

	logic [ELEM_ADDR_W-1:0] stack_mem [ENTRIES];

	logic [CMP_W-1:0]       epb_ext;
	logic [LEN_W-1:0]       len;
	logic [BLK_W+LEN_W-1:0] cap_full;
	logic [POS_W-1:0]       cap;
	logic [POS_W-1:0]       pos_dec;
	logic [AW+BASE_W-1:0]   base_ext;
	logic [AW+PROD_W-1:0]   prod_ext;
	logic [AW+STRIDE_W-1:0] stride_ext;
	logic [AW+ELEM_ADDR_W-1:0] acc_ext;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_wa;
	logic [ELEM_ADDR_W-1:0] mem_wd;

	// Block size clamped into 1..BLOCK_DEPTH.
	assign epb_ext = CMP_W'(epb_q);
	always_comb begin
		if (epb_q == '0) begin
			len = LEN_W'(1);
		end else if (epb_ext > CMP_W'(BLOCK_DEPTH)) begin
			len = LEN_W'(BLOCK_DEPTH);
		end else begin
			len = epb_ext[LEN_W-1:0];
		end
	end

	assign cap_full = blocks_q * len;
	assign cap      = cap_full[POS_W-1:0];
	assign pos_dec  = pos_q - POS_W'(1);

	// Address arithmetic wraps at ADDRESS_BITS.
	assign base_ext   = {{AW{1'b0}}, base_q};
	assign prod_ext   = {{AW{1'b0}}, prod_q};
	assign stride_ext = {{AW{1'b0}}, stride_q};
	assign acc_ext    = {{ELEM_ADDR_W{1'b0}}, acc_q};

	assign sts.pos_ge_cap  = (pos_q >= cap);
	assign sts.blocks_full = (blocks_q == BLK_W'(MAX_BLOCKS));
	assign sts.pos_zero    = (pos_q == '0);
	assign sts.cap_zero    = (cap == '0);
	assign sts.fill_last   = ((fill_idx_q + POS_W'(1)) == fill_end_q);
	assign sts.addr_null   = (free_address == '0);

	assign mem_we = cmd.push | cmd.fill;
	assign mem_wa = cmd.push ? pos_dec[IDX_W-1:0] : fill_idx_q[IDX_W-1:0];
	assign mem_wd = cmd.push ? free_address : acc_ext[ELEM_ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		if (cmd.pop) begin
			rd_q <= stack_mem[pos_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epb_q    <= EPB_RESET;
			stride_q <= STRIDE_RESET;
			base_q   <= BASE_RESET;
			blocks_q <= '0;
			pos_q    <= '0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					CFG_ELEMENTS_PER_BLOCK: epb_q    <= cfg_data[EPB_W-1:0];
					CFG_ELEMENT_STRIDE:     stride_q <= cfg_data[STRIDE_W-1:0];
					CFG_POOL_BASE:          base_q   <= cfg_data[BASE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.pop) begin
				pos_q <= pos_q + POS_W'(1);
			end else if (cmd.push) begin
				pos_q <= pos_dec;
			end else if (cmd.clear_pos) begin
				pos_q <= '0;
			end
			if (cmd.bump_blocks) begin
				blocks_q <= blocks_q + BLK_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_append) begin
			fill_idx_q <= cap;
			fill_end_q <= cap + POS_W'(len);
		end else if (cmd.start_free_all) begin
			fill_idx_q <= '0;
			fill_end_q <= cap;
		end else if (cmd.fill) begin
			fill_idx_q <= fill_idx_q + POS_W'(1);
		end
		if (cmd.mul) begin
			prod_q <= fill_idx_q * stride_q;
		end
		if (cmd.start_free_all) begin
			acc_q <= base_ext[AW-1:0];
		end else if (cmd.add_base) begin
			acc_q <= base_ext[AW-1:0] + prod_ext[AW-1:0];
		end else if (cmd.fill) begin
			acc_q <= acc_q + stride_ext[AW-1:0];
		end
		if (cmd.load_out) begin
			element_address_q <= cmd.out_use_rd ? rd_q : '0;
			status_q          <= cmd.out_status;
		end
	end

	assign element_address = element_address_q;
	assign status          = status_q;

endmodule

FILE: src/fspa_ctrl.sv
// Controller state machine of the pool allocator.
// Drives fspa_cmd_t to the datapath from fspa_sts_t and the handshakes; uses fspa_pkg.
module fspa_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [fspa_pkg::ACTION_W-1:0]    action,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  fspa_pkg::fspa_sts_t              sts,
	output fspa_pkg::fspa_cmd_t              cmd
);
	import fspa_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MUL    = 3'd1;
	localparam logic [2:0] S_BASE   = 3'd2;
	localparam logic [2:0] S_FILL   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0]          state_q, state_d;
	logic                append_q, append_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                res_use_rd_q, res_use_rd_d;
	logic                out_valid_q;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		append_d     = append_q;
		res_status_d = res_status_q;
		res_use_rd_d = res_use_rd_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_status_d = ST_OK;
					res_use_rd_d = 1'b0;
					state_d      = S_RESULT;
					unique case (action)
						ACT_ALLOC: begin
							if (!sts.pos_ge_cap) begin
								cmd.pop      = 1'b1;
								res_use_rd_d = 1'b1;
							end else if (!sts.blocks_full) begin
								cmd.start_append = 1'b1;
								append_d         = 1'b1;
								state_d          = S_MUL;
							end else begin
								res_status_d = ST_OOM;
							end
						end
						ACT_FREE: begin
							if (sts.addr_null) begin
								res_status_d = ST_NULL_FREE;
							end else if (sts.pos_zero) begin
								res_status_d = ST_UNDERFLOW;
							end else begin
								cmd.push = 1'b1;
							end
						end
						ACT_FREE_ALL: begin
							cmd.clear_pos      = 1'b1;
							cmd.start_free_all = 1'b1;
							append_d           = 1'b0;
							if (!sts.cap_zero) begin
								state_d = S_FILL;
							end
						end
						default: ;
					endcase
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_BASE;
			end
			S_BASE: begin
				cmd.add_base = 1'b1;
				state_d      = S_FILL;
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_last) begin
					cmd.bump_blocks = append_q;
					state_d         = append_q ? S_CHECK : S_RESULT;
				end
			end
			S_CHECK: begin
				// The capacity now includes the block just appended.
				if (!sts.pos_ge_cap) begin
					cmd.pop      = 1'b1;
					res_status_d = ST_OK;
					res_use_rd_d = 1'b1;
				end else begin
					res_status_d = ST_OOM;
					res_use_rd_d = 1'b0;
				end
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out   = 1'b1;
					cmd.out_status = res_status_q;
					cmd.out_use_rd = res_use_rd_q;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			append_q     <= 1'b0;
			res_status_q <= ST_OK;
			res_use_rd_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			append_q     <= append_d;
			res_status_q <= res_status_d;
			res_use_rd_q <= res_use_rd_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: src/fspa_checker.sv
// Port-level checks for the pool allocator top level, attached by bind.
// Sees only the top-level ports; uses fspa_pkg for the status codes.
module fspa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [fspa_pkg::ELEM_ADDR_W-1:0] element_address,
	input logic [fspa_pkg::STATUS_W-1:0]    status
);
	import fspa_pkg::*;

	// A result that is not taken holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(element_address) && $stable(status))
		else $error("result changed while stalled");

	// Only a successful result may carry an address.
	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> element_address == '0)
		else $error("failed result carries an address");

	// Every accepted request leaves the block busy after the transfer.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken in back-to-back cycles");

	// A new result appears only at the end of a busy period.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while idle");

endmodule

bind fixed_size_pool_allocator_core fspa_checker u_fspa_checker (.*);

FILE: tb/sv/tb_fixed_size_pool_allocator_core.sv
// Self-checking testbench for the fixed-size pool allocator core.
// Holds its own model of the free-address stack inside a small scoreboard class.
// Depends on fspa_pkg and fixed_size_pool_allocator_core only.
module tb_fixed_size_pool_allocator_core;
	import fspa_pkg::*;

	// Sizes of the instance under test; the model uses the same ones.
	localparam int MAX_BLOCKS   = 16;
	localparam int BLOCK_DEPTH  = 64;
	localparam int STACK_SIZE   = MAX_BLOCKS * BLOCK_DEPTH;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int PHASE_ITEMS  = 130;
	localparam int PHASE_COUNT  = 10;

	// The action code that the block accepts but does nothing with.
	localparam logic [ACTION_W-1:0] ACT_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [ELEM_ADDR_W-1:0] addr;
		logic [STATUS_W-1:0]    st;
	} alloc_result_t;

	// Scoreboard: mirrors the stack of free addresses and keeps the results
	// that the block still owes, oldest first.
	class pool_checker;
		logic [ELEM_ADDR_W-1:0] free_list [STACK_SIZE];
		int                     blocks_live;
		int                     handed_out;
		logic [EPB_W-1:0]       cfg_epb;
		logic [STRIDE_W-1:0]    cfg_stride;
		logic [BASE_W-1:0]      cfg_base;
		alloc_result_t          pending_results [$];
		int                     errors;

		function new();
			blocks_live = 0;
			handed_out  = 0;
			cfg_epb     = EPB_RESET;
			cfg_stride  = STRIDE_RESET;
			cfg_base    = BASE_RESET;
			errors      = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ELEMENTS_PER_BLOCK: cfg_epb = data[EPB_W-1:0];
				CFG_ELEMENT_STRIDE:     cfg_stride = data[STRIDE_W-1:0];
				CFG_POOL_BASE:          cfg_base = data[BASE_W-1:0];
				default: ;
			endcase
		endfunction

		// A block size of zero counts as one, anything above the depth as the depth.
		function int block_len();
			if (cfg_epb == 0)
				return 1;
			if (int'(cfg_epb) > BLOCK_DEPTH)
				return BLOCK_DEPTH;
			return int'(cfg_epb);
		endfunction

		// Element k lives at base + k * stride, wrapping at 32 bits.
		function void fill_entries(int first, int count);
			for (int i = 0; i < count; i++) begin
				if (first + i < STACK_SIZE)
					free_list[first + i] = cfg_base + 32'(first + i) * {16'd0, cfg_stride};
			end
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction

		// Notes one accepted request, updates the model and queues its result.
		function alloc_result_t accept_request(logic [ACTION_W-1:0] act,
				logic [ELEM_ADDR_W-1:0] addr);
			alloc_result_t res;
			int len;
			int cap;
			res.addr = '0;
			res.st   = ST_OK;
			len      = block_len();
			case (act)
				ACT_ALLOC: begin
					cap = blocks_live * len;
					if (handed_out >= cap && blocks_live < MAX_BLOCKS) begin
						fill_entries(cap, len);
						blocks_live++;
						cap += len;
					end
					if (handed_out < cap && handed_out < STACK_SIZE) begin
						res.addr = free_list[handed_out];
						handed_out++;
					end else begin
						res.st = ST_OOM;
					end
				end
				ACT_FREE: begin
					if (addr == '0) begin
						res.st = ST_NULL_FREE;
					end else if (handed_out == 0) begin
						res.st = ST_UNDERFLOW;
					end else begin
						handed_out--;
						free_list[handed_out] = addr;
					end
				end
				ACT_FREE_ALL: begin
					handed_out = 0;
					fill_entries(0, blocks_live * len);
				end
				default: ;
			endcase
			pending_results.push_back(res);
			return res;
		endfunction

		function void compare_result(logic [ELEM_ADDR_W-1:0] addr, logic [STATUS_W-1:0] st);
			alloc_result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected, element_address %h status %0d",
					$time, addr, st);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (addr !== want.addr) begin
				$display("%0t: element_address expected %h actual %h", $time, want.addr, addr);
				errors++;
			end
			if (st !== want.st) begin
				$display("%0t: status expected %0d actual %0d", $time, want.st, st);
				errors++;
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    cfg_write_enable;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [ACTION_W-1:0]     action;
	logic [ELEM_ADDR_W-1:0]  free_address;
	logic                    out_valid;
	logic                    out_ready;
	logic [ELEM_ADDR_W-1:0]  element_address;
	logic [STATUS_W-1:0]     status;

	pool_checker             sb;

	// Addresses the stimulus currently holds, so that most frees return
	// something that was really handed out.
	logic [ELEM_ADDR_W-1:0]  live_addrs [$];

	// Random idling switches: the sender inserts gaps before items, the
	// receiver drops ready for bursts. Both are cleared for the closing phase.
	bit                      tx_gaps_on;
	bit                      rx_stall_on;

	fixed_size_pool_allocator_core #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.BLOCK_DEPTH  (BLOCK_DEPTH),
		.ADDRESS_BITS (32)
	) i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.action           (action),
		.free_address     (free_address),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.element_address  (element_address),
		.status           (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog. The slowest legal run stays far below this limit, with its
	// free-all passes, block appends, and the gaps and stalls between items.
	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Result side. Outputs are sampled at the rising edge, so the values seen
	// are those that the block presented during the transfer. Ready is then
	// chosen for the next cycle with a single nonblocking assignment.
	initial begin
		int  results_seen;
		int  stall_left;
		int  hold_left;
		bit  held;
		results_seen = 0;
		stall_left   = 0;
		hold_left    = 0;
		held         = 1'b0;
		out_ready    = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.compare_result(element_address, status);
				results_seen++;
			end
			// Once in the run the receiver holds off for a long stretch while
			// the sender keeps offering requests, so the block fills up and
			// has to stall its request channel.
			if (results_seen >= 300 && !held) begin
				held      = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_stall_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offers one request and returns once it is transferred. A gap, if any,
	// comes before the item, so valid is never lowered in the step where the
	// next item raises it. Must be called at a rising edge.
	task automatic send_request(logic [ACTION_W-1:0] act, logic [ELEM_ADDR_W-1:0] addr);
		alloc_result_t res;
		if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		free_address <= addr;
		do
			@(posedge clk);
		while (!in_ready);
		res = sb.accept_request(act, addr);
		if (act == ACT_ALLOC && res.st == ST_OK)
			live_addrs.push_back(res.addr);
		else if (act == ACT_FREE_ALL)
			live_addrs.delete();
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write_enable <= 1'b1;
		cfg_index        <= idx;
		cfg_data         <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Waits until every owed result has arrived and the block has had time
	// to finish whatever it was still doing.
	task automatic drain(int settle);
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// One configuration phase: reconfigure while idle, then start with a
	// free-all. The free-all rewrites every set-up entry under the new block
	// size, so no allocate can ever land on an entry that was never written.
	// The rest is a mix of allocates, frees of held addresses, and noise.
	task automatic run_phase(logic [EPB_W-1:0] epb, logic [STRIDE_W-1:0] stride,
			logic [BASE_W-1:0] base, int n, int alloc_w);
		int                     sent;
		int                     r;
		int                     k;
		logic [ACTION_W-1:0]    act;
		logic [ELEM_ADDR_W-1:0] addr;
		drain(8);
		write_reg(CFG_ELEMENTS_PER_BLOCK, {25'd0, epb});
		write_reg(CFG_ELEMENT_STRIDE, {16'd0, stride});
		write_reg(CFG_POOL_BASE, base);
		cfg_write_enable <= 1'b0;
		send_request(ACT_FREE_ALL, $urandom);
		sent = 0;
		while (sent < n) begin
			r    = $urandom_range(0, 99);
			addr = $urandom;
			if (r < alloc_w) begin
				act = ACT_ALLOC;
			end else if (r < 86 && live_addrs.size() > 0) begin
				k    = $urandom_range(0, live_addrs.size() - 1);
				act  = ACT_FREE;
				addr = live_addrs[k];
				live_addrs.delete(k);
			end else if (r < 91) begin
				act = ACT_FREE;
			end else if (r < 94) begin
				act  = ACT_FREE;
				addr = '0;
			end else if (r < 97) begin
				act = ACT_FREE_ALL;
			end else begin
				act = ACT_UNKNOWN;
			end
			send_request(act, addr);
			if (act != ACT_UNKNOWN)
				sent++;
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [EPB_W-1:0]    epb;
		logic [STRIDE_W-1:0] stride;
		logic [BASE_W-1:0]   base;
		sb               = new();
		arst_n           = 1'b0;
		cfg_write_enable = 1'b0;
		cfg_index        = CFG_ELEMENTS_PER_BLOCK;
		cfg_data         = '0;
		in_valid         = 1'b0;
		action           = ACT_ALLOC;
		free_address     = '0;
		tx_gaps_on       = 1'b1;
		rx_stall_on      = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset configuration. A free before any
		// block exists underflows, a null free is ignored, the unknown
		// action does nothing, and the first allocate appends a block.
		send_request(ACT_FREE, 32'hFFFF_FFFF);
		send_request(ACT_FREE, 32'h0);
		send_request(ACT_UNKNOWN, 32'hAAAA_AAAA);
		send_request(ACT_ALLOC, 32'h5555_5555);
		send_request(ACT_ALLOC, 32'h0);
		send_request(ACT_FREE, 32'h5555_5555);
		send_request(ACT_FREE, 32'hFFFF_FFFF);
		send_request(ACT_ALLOC, 32'h0);
		in_valid <= 1'b0;

		// Extreme settings: a block size of zero acts as one element, the
		// largest stride from the top of the address space wraps every address after the first,
		// and the seventeenth allocate finds every block in use.
		run_phase(7'd0, 16'hFFFF, 32'hFFFF_FFFF, 0, 0);
		repeat (MAX_BLOCKS + 1) send_request(ACT_ALLOC, $urandom);
		in_valid <= 1'b0;

		// Random phases. The first few pin the remaining extremes; the rest
		// favor small blocks so that running out of memory is common.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					epb = 7'd127; stride = 16'd1; base = 32'h0;
				end
				1: begin
					epb = 7'd64; stride = 16'hFFFF; base = 32'hFFFF_0000;
				end
				2: begin
					epb = 7'd1; stride = 16'd0; base = 32'h1;
				end
				default: begin
					epb    = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
						: 7'($urandom_range(1, 8));
					stride = 16'($urandom);
					base   = $urandom;
				end
			endcase
			// The closing phase runs without any idling on either side.
			tx_gaps_on  = (p == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
			rx_stall_on = (p == PHASE_COUNT - 1) ? 1'b0 : ($urandom_range(0, 2) != 0);
			run_phase(epb, stride, base, PHASE_ITEMS, (p % 2 == 0) ? 45 : 70);
		end

		drain(20);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
